// File: hw/rtl/ddfp_pkg.sv
package ddfp_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int FIXED_BYTES     = 17;
    localparam int FIX_DATA_BYTES  = FIXED_BYTES - 1;

    localparam int BYTE_CNT_W = $clog2(MAX_FRAME_BYTES + 2);
    localparam int FIX_OFF_W  = $clog2(FIXED_BYTES + 2);

    localparam logic [7:0] RESTART_CODE = 8'h01;
    localparam logic [7:0] NAME_TERM    = 8'h00;
    localparam logic [7:0] NAME_CNT_MAX = 8'hFF;

    localparam logic KIND_NAME  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_BAD      = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [7:0]  name_char;
        logic [1:0]  status;
        logic [31:0] write_block_size;
        logic [31:0] read_block_size;
        logic [31:0] program_size;
        logic [15:0] write_timeout;
        logic [15:0] prepare_timeout;
        logic        restart_flag;
        logic [7:0]  name_length;
    } t_result;

endpackage

// File: hw/rtl/ddfp_core.sv
module ddfp_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_frame_end,
    output logic             o_res_valid,
    output ddfp_pkg::t_result o_res
);
    import ddfp_pkg::*;

    logic [BYTE_CNT_W-1:0] r_byte_cnt, n_byte_cnt;
    logic                  r_in_name, n_in_name;
    logic [7:0]            r_name_cnt, n_name_cnt;
    logic [FIX_OFF_W-1:0]  r_fix_off, n_fix_off;
    logic [7:0]            r_fix [FIX_DATA_BYTES];
    logic [7:0]            n_fix [FIX_DATA_BYTES];
    logic                  r_restart, n_restart;
    logic                  echo;
    logic                  store;
    logic [1:0]            status;

    always_comb begin
        n_byte_cnt = r_byte_cnt;
        if (r_byte_cnt < BYTE_CNT_W'(MAX_FRAME_BYTES + 1)) begin
            n_byte_cnt = r_byte_cnt + 1'b1;
        end

        n_in_name  = r_in_name;
        n_name_cnt = r_name_cnt;
        n_fix_off  = r_fix_off;
        echo       = 1'b0;
        store      = 1'b0;
        if (r_in_name) begin
            if (i_rx_byte == NAME_TERM) begin
                n_in_name = 1'b0;
            end else begin
                if (r_name_cnt != NAME_CNT_MAX) begin
                    n_name_cnt = r_name_cnt + 1'b1;
                end
                echo = !i_frame_end;
            end
        end else begin
            store = 1'b1;
            if (r_fix_off < FIX_OFF_W'(FIXED_BYTES + 1)) begin
                n_fix_off = r_fix_off + 1'b1;
            end
        end

        for (int k = 0; k < FIX_DATA_BYTES; k++) begin
            n_fix[k] = (store && r_fix_off == FIX_OFF_W'(k)) ? i_rx_byte : r_fix[k];
        end
        n_restart = r_restart;
        if (store && r_fix_off == FIX_OFF_W'(FIX_DATA_BYTES)) begin
            n_restart = (i_rx_byte == RESTART_CODE);
        end

        if (n_byte_cnt > BYTE_CNT_W'(MAX_FRAME_BYTES)) begin
            status = ST_OVERFLOW;
        end else if (n_in_name || n_fix_off != FIX_OFF_W'(FIXED_BYTES)) begin
            status = ST_BAD;
        end else begin
            status = ST_OK;
        end

        o_res       = '0;
        o_res_valid = i_frame_end || echo;
        if (i_frame_end) begin
            o_res.kind   = KIND_FINAL;
            o_res.status = status;
            if (status == ST_OK) begin
                o_res.write_block_size = {n_fix[3], n_fix[2], n_fix[1], n_fix[0]};
                o_res.read_block_size  = {n_fix[7], n_fix[6], n_fix[5], n_fix[4]};
                o_res.program_size     = {n_fix[11], n_fix[10], n_fix[9], n_fix[8]};
                o_res.write_timeout    = {n_fix[13], n_fix[12]};
                o_res.prepare_timeout  = {n_fix[15], n_fix[14]};
                o_res.restart_flag     = n_restart;
                o_res.name_length      = n_name_cnt;
            end
        end else begin
            o_res.kind      = KIND_NAME;
            o_res.name_char = i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt <= '0;
            r_in_name  <= 1'b1;
            r_name_cnt <= '0;
            r_fix_off  <= '0;
        end else if (i_accept) begin
            if (i_frame_end) begin
                r_byte_cnt <= '0;
                r_in_name  <= 1'b1;
                r_name_cnt <= '0;
                r_fix_off  <= '0;
            end else begin
                r_byte_cnt <= n_byte_cnt;
                r_in_name  <= n_in_name;
                r_name_cnt <= n_name_cnt;
                r_fix_off  <= n_fix_off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_fix     <= n_fix;
            r_restart <= n_restart;
        end
    end

endmodule

// File: hw/rtl/device_descriptor_frame_parser.sv
// Each result item is registered in the result register (or the skid stage) before o_valid.
// Throughput: one input item per cycle while o_stall is low; the parse state advances in a single pass.
// A result register plus a one-entry skid stage decouple the sides, so input is
// stalled only once the skid stage holds an item.
// Reset is synchronous and active low; it clears the frame counters and both output stages.
module device_descriptor_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_name_char,
    output logic [1:0]  o_status,
    output logic [31:0] o_write_block_size,
    output logic [31:0] o_read_block_size,
    output logic [31:0] o_program_size,
    output logic [15:0] o_write_timeout,
    output logic [15:0] o_prepare_timeout,
    output logic        o_restart_flag,
    output logic [7:0]  o_name_length
);
    import ddfp_pkg::*;

    logic    accept;
    logic    pop;
    logic    push;
    logic    res_valid;
    t_result res;
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;

    assign o_stall = r_skid_valid;
    assign accept  = i_valid && !r_skid_valid;
    assign pop     = r_out_valid && !i_stall;
    assign push    = accept && res_valid;

    ddfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_frame_end (i_frame_end),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || pop) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = res;
                n_out_valid = push;
            end
        end else if (push) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid            = r_out_valid;
    assign o_result_kind      = r_out.kind;
    assign o_name_char        = r_out.name_char;
    assign o_status           = r_out.status;
    assign o_write_block_size = r_out.write_block_size;
    assign o_read_block_size  = r_out.read_block_size;
    assign o_program_size     = r_out.program_size;
    assign o_write_timeout    = r_out.write_timeout;
    assign o_prepare_timeout  = r_out.prepare_timeout;
    assign o_restart_flag     = r_out.restart_flag;
    assign o_name_length      = r_out.name_length;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds an item while the result register is empty");

    a_final_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_frame_end) |=> o_valid)
        else $error("final descriptor item did not reach the output");

    a_name_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == KIND_NAME) |-> (o_status == ST_OK && o_name_length == 8'd0))
        else $error("name item carries descriptor fields");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == KIND_FINAL && o_status != ST_OK)
            |-> (o_name_length == 8'd0 && o_write_block_size == 32'd0 && !o_restart_flag))
        else $error("failed descriptor item carries decoded fields");

endmodule
